### rtl/i2a_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package i2a_pkg;

  // Command codes
  localparam logic [1:0] CMD_SDEC = 2'd0;
  localparam logic [1:0] CMD_UDEC = 2'd1;
  localparam logic [1:0] CMD_HEXL = 2'd2;
  localparam logic [1:0] CMD_HEXU = 2'd3;

  // Digit buffer: 20 BCD digits cover a 64-bit operand
  localparam int unsigned NUM_DIGITS = 20;
  localparam int unsigned BCD_W      = 4 * NUM_DIGITS;
  localparam int unsigned HEX_DIGITS = 8;

  localparam logic [7:0] CHR_ZERO  = 8'h30;
  localparam logic [7:0] CHR_LOWER = 8'h61;
  localparam logic [7:0] CHR_UPPER = 8'h41;
  localparam logic [7:0] CHR_MINUS = 8'h2d;

  typedef struct packed {
    logic [1:0]  cmd;
    logic        wide;
    logic [63:0] value;
  } in_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       last;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_SIGN,
    ST_EMIT
  } state_t;

  // One shift-and-add-3 step: adjust every digit, then shift one bit in
  function automatic logic [BCD_W-1:0] dd_step(input logic [BCD_W-1:0] bcd,
                                               input logic bit_in);
    logic [BCD_W-1:0] adj;
    adj = bcd;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end
    end
    return {adj[BCD_W-2:0], bit_in};
  endfunction

  // Digit value to ASCII
  function automatic logic [7:0] to_ascii(input logic [3:0] d, input logic upper);
    logic [7:0] c;
    if (d <= 4'd9) begin
      c = CHR_ZERO + {4'd0, d};
    end else if (upper) begin
      c = CHR_UPPER + {4'd0, d} - 8'd10;
    end else begin
      c = CHR_LOWER + {4'd0, d} - 8'd10;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

### rtl/integer_to_ascii_formatter.sv
// Busy covers the conversion (two bits per cycle through chained shift-and-add-3 steps,
// none for hex), the dropping of leading zeros, an optional minus sign and then the
// characters, most significant first. Characters leave through a register, so the last
// one shows in the first idle cycle; a new number is taken only while idle, which can be
// that same first idle cycle. The receiver cannot stall.
// Synchronous active-low reset returns to idle.
`timescale 1ns / 1ps
`default_nettype none

module integer_to_ascii_formatter (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  output logic               busy,
  input  wire i2a_pkg::in_t  in_data,
  output logic               out_valid,
  output i2a_pkg::out_t      out_data
);
  import i2a_pkg::*;

  state_t           state_r, state_nxt;
  logic [BCD_W-1:0] bcd_r, bcd_nxt;
  logic [63:0]      sh_r, sh_nxt;
  logic [4:0]       cnt_r, cnt_nxt;
  logic             neg_r, neg_nxt;
  logic             upper_r, upper_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_t             out_data_r, out_data_nxt;

  logic [BCD_W-1:0] step1;
  logic [3:0]       top_digit;
  logic             in_neg;
  logic [63:0]      mag64;
  logic [31:0]      mag32;

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign top_digit = bcd_r[BCD_W-1 -: 4];
  assign step1     = dd_step(bcd_r, sh_r[63]);

  // Sign and magnitude of the incoming operand
  always_comb begin
    in_neg = 1'b0;
    if (in_data.cmd == CMD_SDEC) begin
      in_neg = in_data.wide ? in_data.value[63] : in_data.value[31];
    end
    mag64 = in_neg ? (~in_data.value + 64'd1) : in_data.value;
    mag32 = in_neg ? (~in_data.value[31:0] + 32'd1) : in_data.value[31:0];
  end

  // State register and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    bcd_r      <= bcd_nxt;
    sh_r       <= sh_nxt;
    cnt_r      <= cnt_nxt;
    neg_r      <= neg_nxt;
    upper_r    <= upper_nxt;
    out_data_r <= out_data_nxt;
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    bcd_nxt       = bcd_r;
    sh_nxt        = sh_r;
    cnt_nxt       = cnt_r;
    neg_nxt       = neg_r;
    upper_nxt     = upper_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          neg_nxt   = in_neg;
          upper_nxt = (in_data.cmd == CMD_HEXU);
          if (in_data.cmd == CMD_HEXL || in_data.cmd == CMD_HEXU) begin
            // Hex digits are the operand nibbles themselves
            bcd_nxt   = {in_data.value[31:0], {(BCD_W - 32){1'b0}}};
            cnt_nxt   = 5'(HEX_DIGITS);
            state_nxt = ST_SKIP;
          end else begin
            bcd_nxt   = '0;
            if (in_data.wide) begin
              sh_nxt  = mag64;
              cnt_nxt = 5'd31;
            end else begin
              sh_nxt  = {mag32, 32'd0};
              cnt_nxt = 5'd15;
            end
            state_nxt = ST_CONV;
          end
        end
      end

      // Binary to BCD, two bits per cycle
      ST_CONV: begin
        bcd_nxt = dd_step(step1, sh_r[62]);
        sh_nxt  = {sh_r[61:0], 2'b00};
        if (cnt_r == 5'd0) begin
          cnt_nxt   = 5'(NUM_DIGITS);
          state_nxt = ST_SKIP;
        end else begin
          cnt_nxt = cnt_r - 5'd1;
        end
      end

      // Drop leading zeros, always keeping one digit
      ST_SKIP: begin
        if (top_digit == 4'd0 && cnt_r != 5'd1) begin
          bcd_nxt = {bcd_r[BCD_W-5:0], 4'd0};
          cnt_nxt = cnt_r - 5'd1;
        end else begin
          state_nxt = neg_r ? ST_SIGN : ST_EMIT;
        end
      end

      ST_SIGN: begin
        out_valid_nxt         = 1'b1;
        out_data_nxt.char_out = CHR_MINUS;
        out_data_nxt.last     = 1'b0;
        state_nxt             = ST_EMIT;
      end

      // One character per cycle, most significant first
      ST_EMIT: begin
        out_valid_nxt         = 1'b1;
        out_data_nxt.char_out = to_ascii(top_digit, upper_r);
        out_data_nxt.last     = (cnt_r == 5'd1);
        bcd_nxt               = {bcd_r[BCD_W-5:0], 4'd0};
        cnt_nxt               = cnt_r - 5'd1;
        if (cnt_r == 5'd1) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### tb/integer_to_ascii_formatter_tb.sv
`timescale 1ns / 1ps

module integer_to_ascii_formatter_tb;
  import i2a_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 330;
  localparam int DRAIN_CYCLES = 60;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  in_t  in_data = '0;
  logic busy;
  logic out_valid;
  out_t out_data;

  // Characters still owed by the block, oldest first
  out_t expected_chars[$];

  int   mismatch_count = 0;
  int   numbers_sent = 0;
  int   chars_checked = 0;
  int   cycle_count = 0;
  logic no_gaps = 1'b0;

  integer_to_ascii_formatter i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d characters outstanding", cycle_count,
               expected_chars.size());
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("MISMATCH at %0t: %s, got %h expected %h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // Expected character stream of one number, appended to expected_chars
  function automatic void predict_chars(input in_t item);
    logic [63:0] mag;
    logic [63:0] base;
    logic [63:0] digit;
    logic [31:0] lo;
    logic [7:0]  alpha;
    logic [7:0]  digs [NUM_DIGITS];
    logic        neg;
    int          n;
    int          k;
    out_t        ch;
    lo    = item.value[31:0];
    mag   = '0;
    neg   = 1'b0;
    base  = 64'd10;
    alpha = CHR_LOWER;
    case (item.cmd)
      CMD_SDEC: begin
        if (item.wide) begin
          neg = item.value[63];
          mag = neg ? (~item.value + 64'd1) : item.value;
        end else begin
          // narrow: bit 31 is the sign, the upper word is ignored
          neg = lo[31];
          mag = {32'd0, (neg ? (~lo + 32'd1) : lo)};
        end
      end
      CMD_UDEC: begin
        mag = item.wide ? item.value : {32'd0, lo};
      end
      CMD_HEXL: begin
        base = 64'd16;
        mag  = {32'd0, lo};
      end
      CMD_HEXU: begin
        base  = 64'd16;
        alpha = CHR_UPPER;
        mag   = {32'd0, lo};
      end
    endcase

    // digits come out least significant first
    n = 0;
    do begin
      digit = mag % base;
      mag   = mag / base;
      digs[n] = (digit <= 64'd9) ? (CHR_ZERO + digit[7:0]) : (alpha + digit[7:0] - 8'd10);
      n++;
    end while (mag != 64'd0 && n < NUM_DIGITS);

    if (neg) begin
      ch.char_out = CHR_MINUS;
      ch.last     = 1'b0;
      expected_chars.push_back(ch);
    end
    for (k = n - 1; k >= 0; k--) begin
      ch.char_out = digs[k];
      ch.last     = (k == 0);
      expected_chars.push_back(ch);
    end
  endfunction

  // One transaction: optional idle gap, then hold start until busy is low at an edge
  task automatic send_number(input logic [1:0] cmd, input logic wide,
                             input logic [63:0] value);
    int   gap;
    in_t  item;
    gap = no_gaps ? 0 : $urandom_range(0, 14);
    item.cmd   = cmd;
    item.wide  = wide;
    item.value = value;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (busy);
    predict_chars(item);
    numbers_sent++;
  endtask

  // Result checker: every strobed character against the oldest expectation
  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid) begin
      if (expected_chars.size() == 0) begin
        report_mismatch("unexpected character", out_data.char_out, 8'h00);
      end else begin
        want = expected_chars.pop_front();
        chars_checked++;
        if (out_data.char_out !== want.char_out) begin
          report_mismatch("char_out", out_data.char_out, want.char_out);
        end
        if (out_data.last !== want.last) begin
          report_mismatch("last", {7'd0, out_data.last}, {7'd0, want.last});
        end
      end
    end
  end

  // Signed decimal: zero, sign handling, both most negative values
  task automatic test_signed_decimal();
    send_number(CMD_SDEC, 1'b0, 64'h0000_0000_0000_0000);
    send_number(CMD_SDEC, 1'b0, 64'h0000_0000_0000_0001);
    send_number(CMD_SDEC, 1'b0, 64'h1234_5678_FFFF_FFFF);
    send_number(CMD_SDEC, 1'b0, 64'hFFFF_FFFF_8000_0000);
    send_number(CMD_SDEC, 1'b0, 64'hFFFF_FFFF_7FFF_FFFF);
    send_number(CMD_SDEC, 1'b1, 64'h0000_0000_0000_0000);
    send_number(CMD_SDEC, 1'b1, 64'h8000_0000_0000_0000);
    send_number(CMD_SDEC, 1'b1, 64'h7FFF_FFFF_FFFF_FFFF);
    send_number(CMD_SDEC, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF);
  endtask

  // Unsigned decimal: narrow ignores the upper word, wide reaches 20 digits
  task automatic test_unsigned_decimal();
    send_number(CMD_UDEC, 1'b0, 64'hDEAD_BEEF_FFFF_FFFF);
    send_number(CMD_UDEC, 1'b0, 64'hFFFF_FFFF_0000_0000);
    send_number(CMD_UDEC, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF);
    send_number(CMD_UDEC, 1'b1, 64'h0000_0000_0000_0000);
    send_number(CMD_UDEC, 1'b1, 64'h0DE0_B6B3_A764_0000);
  endtask

  // Hex: low word only, whatever wide says; both letter cases
  task automatic test_hex();
    send_number(CMD_HEXL, 1'b1, 64'hFFFF_FFFF_0000_0000);
    send_number(CMD_HEXL, 1'b1, 64'h0123_4567_89AB_CDEF);
    send_number(CMD_HEXL, 1'b0, 64'h0000_0000_FEDC_BA98);
    send_number(CMD_HEXU, 1'b0, 64'h0000_0000_0000_0000);
    send_number(CMD_HEXU, 1'b1, 64'h0123_4567_89AB_CDEF);
    send_number(CMD_HEXU, 1'b0, 64'hAAAA_AAAA_FFFF_FFFF);
  endtask

  // Random numbers of every length; bursts without gaps and gapped stretches are picked at random
  task automatic test_random();
    logic [63:0] value;
    logic [63:0] raw;
    int          i;
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 40 == 0) begin
        no_gaps = ($urandom_range(0, 2) == 0);
      end
      raw = {$urandom, $urandom};
      case ($urandom_range(0, 4))
        0: value = raw;
        1: value = raw >> $urandom_range(0, 63);
        2: value = 64'($urandom_range(0, 20));
        3: value = ~(raw >> $urandom_range(1, 63));
        default: begin
          // narrow negatives with junk in the upper word
          value = {raw[63:32], ~(raw[31:0] >> $urandom_range(1, 31))};
        end
      endcase
      send_number(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), value);
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_signed_decimal();
    test_unsigned_decimal();
    test_hex();
    test_random();

    start <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Converted %0d numbers in all four modes and both widths, %0d characters checked",
             numbers_sent, chars_checked);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
